// File: hdl/ras_pkg.sv
package ras_pkg;

  localparam int NUM_ACTIONS_DEF = 64;
  localparam int COUNT_W = 24;
  localparam int MEAN_W = 18;
  localparam int BIAS_W = 16;
  localparam int BETA_W = 17;
  localparam int DEN_W = 83;
  localparam logic [COUNT_W-1:0] AMAF_INIT = 24'd50;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  typedef enum logic [1:0] {
    CMD_INIT = 2'd0,
    CMD_AMAF = 2'd1,
    CMD_VISIT = 2'd2,
    CMD_SELECT = 2'd3
  } cmd_t;

  localparam logic [2:0] REG_BIAS_ADDR = 3'd0;

  typedef struct packed {
    logic legal;
    logic [COUNT_W-1:0] amaf_count;
    logic signed [MEAN_W-1:0] amaf_mean;
    logic [COUNT_W-1:0] visit_count;
    logic signed [MEAN_W-1:0] visit_mean;
  } entry_t;

endpackage

// File: hdl/ras_ram.sv
module ras_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rave_action_statistics_select.sv
// RAVE action statistics of one tree node, one entry per action in a single
// RAM with registered read. After reset a clearing pass writes every entry to
// zero, during which no beat is taken. Items are handled one at a time: an
// init is written directly; an update reads the entry, runs an 18-step
// shared-subtract divider and, for a legal entry, writes back. A select reads
// the actions in turn through the single RAM read port: an illegal action is
// skipped, a legal one goes through multiplies for the RAVE denominator, then
// a 17-step divider for beta, then the blend (both counts zero go straight to
// the blend). The result sits in an output register; new beats are taken
// while it waits.
module rave_action_statistics_select #(
  parameter int NUM_ACTIONS = ras_pkg::NUM_ACTIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // action[5:0], reward[7:6], legal[8], zero pad
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // best_act[5:0], zero pad
  output logic        m_axis_tuser,  // none_legal[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ras_pkg::*;

  localparam int AW = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_ACTIONS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_UPD_RD, S_UPD_DIV, S_UPD_WR,
    S_SEL_RD, S_SEL_CHK, S_SEL_M0, S_SEL_M1, S_SEL_M2, S_SEL_DEN,
    S_SEL_DIV, S_SEL_BLEND, S_SEL_CMP, S_SEL_OUT
  } state_t;

  state_t state;
  logic [BIAS_W-1:0] bias;
  logic [AW-1:0] clr_idx, idx, upd_addr, best_idx;
  cmd_t cmd_r;
  entry_t ent, ram_rdata, ram_wdata;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;

  logic [COUNT_W-1:0] upd_n;
  logic [MEAN_W-1:0] upd_dvd, upd_quo;
  logic [COUNT_W-1:0] upd_rem;
  logic upd_neg;
  logic [4:0] step;
  logic [1:0] rew_r;

  logic [31:0] bsq;
  logic [47:0] prod;
  logic [55:0] term_lo, term_hi;
  logic [DEN_W+15:0] dsh;
  logic [63:0] num;
  logic [BETA_W-1:0] beta;
  logic signed [36:0] blend_p;
  logic signed [39:0] best_val;
  logic found;

  // input decode
  logic in_accept;
  cmd_t in_cmd;
  logic [AW+5:0] act_w;
  logic act_ok;
  logic [AW-1:0] act_addr;

  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign in_cmd = cmd_t'(s_axis_tuser);
  assign act_w = (AW+6)'(s_axis_tdata[5:0]);
  assign act_ok = act_w < (AW+6)'(NUM_ACTIONS);
  assign act_addr = act_w[AW-1:0];
  assign s_axis_tready = (state == S_IDLE);

  // config port
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_BIAS_ADDR) ? 32'(bias) : 32'd0;

  // update read stage
  logic [COUNT_W-1:0] rd_cnt, rd_n;
  logic signed [MEAN_W-1:0] rd_q;
  logic signed [19:0] rd_z, rd_diff, rd_abs;
  always_comb begin
    rd_cnt = (cmd_r == CMD_AMAF) ? ram_rdata.amaf_count : ram_rdata.visit_count;
    rd_q = (cmd_r == CMD_AMAF) ? ram_rdata.amaf_mean : ram_rdata.visit_mean;
    rd_n = (rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 24'd1;
    rd_z = (rew_r == 2'd1) ? 20'sd65536 : ((rew_r == 2'd0) ? 20'sd0 : -20'sd65536);
    rd_diff = rd_z - 20'(rd_q);
    rd_abs = rd_diff[19] ? -rd_diff : rd_diff;
  end

  // divider step for updates
  logic [COUNT_W:0] upd_sh;
  logic upd_fit;
  assign upd_sh = {upd_rem, upd_dvd[MEAN_W-1]};
  assign upd_fit = upd_sh >= {1'b0, upd_n};

  // write-back value
  logic signed [19:0] delta, new_v;
  logic signed [MEAN_W-1:0] new_q, old_q;
  entry_t upd_ent;
  always_comb begin
    old_q = (cmd_r == CMD_AMAF) ? ent.amaf_mean : ent.visit_mean;
    delta = upd_neg ? -20'(upd_quo) : 20'(upd_quo);
    new_v = 20'(old_q) + delta;
    if (new_v > 20'sd131071) begin
      new_q = 18'sd131071;
    end else if (new_v < -20'sd131072) begin
      new_q = -18'sd131072;
    end else begin
      new_q = new_v[MEAN_W-1:0];
    end
    upd_ent = ent;
    if (cmd_r == CMD_AMAF) begin
      upd_ent.amaf_count = upd_n;
      upd_ent.amaf_mean = new_q;
    end else begin
      upd_ent.visit_count = upd_n;
      upd_ent.visit_mean = new_q;
    end
  end

  // select datapath
  logic [DEN_W-1:0] den;
  logic [79:0] term;
  logic sel_fit;
  logic signed [39:0] cand;
  always_comb begin
    term = 80'(term_lo) + (80'(term_hi) << 24);
    den = (DEN_W'(25'(ent.amaf_count) + 25'(ent.visit_count)) << 24) + (DEN_W'(term) << 2);
    sel_fit = {35'd0, num} >= dsh;
    cand = (40'(ent.visit_mean) <<< 16) + 40'(blend_p);
  end

  // ram port control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = upd_addr;
    ram_wdata = '0;
    ram_raddr = idx;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_idx;
      end
      S_IDLE: begin
        ram_raddr = act_addr;
        if (in_accept && in_cmd == CMD_INIT && act_ok) begin
          ram_we = 1'b1;
          ram_waddr = act_addr;
          ram_wdata.legal = s_axis_tdata[8];
          ram_wdata.amaf_count = AMAF_INIT;
        end
      end
      S_UPD_WR: begin
        ram_we = 1'b1;
        ram_wdata = upd_ent;
      end
      default: begin
        ram_raddr = idx;
      end
    endcase
  end

  ras_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_ACTIONS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      bias <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b0;
      found <= 1'b0;
      idx <= '0;
    end else begin
      if (cfg_we && paddr == REG_BIAS_ADDR) begin
        bias <= pwdata[BIAS_W-1:0];
      end
      if (m_axis_tready && state != S_SEL_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            cmd_r <= in_cmd;
            rew_r <= s_axis_tdata[7:6];
            upd_addr <= act_addr;
            if (in_cmd == CMD_SELECT) begin
              idx <= '0;
              found <= 1'b0;
              bsq <= 32'(bias) * 32'(bias);
              state <= S_SEL_RD;
            end else if (in_cmd != CMD_INIT && act_ok) begin
              state <= S_UPD_RD;
            end
          end
        end
        S_UPD_RD: begin
          ent <= ram_rdata;
          upd_n <= rd_n;
          upd_dvd <= rd_abs[MEAN_W-1:0];
          upd_neg <= rd_diff[19];
          upd_rem <= '0;
          upd_quo <= '0;
          step <= 5'd17;
          state <= ram_rdata.legal ? S_UPD_DIV : S_IDLE;
        end
        S_UPD_DIV: begin
          upd_rem <= upd_fit ? COUNT_W'(upd_sh - {1'b0, upd_n}) : upd_sh[COUNT_W-1:0];
          upd_quo <= {upd_quo[MEAN_W-2:0], upd_fit};
          upd_dvd <= upd_dvd << 1;
          step <= step - 5'd1;
          if (step == 5'd0) begin
            state <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          state <= S_IDLE;
        end
        S_SEL_RD: begin
          state <= S_SEL_CHK;
        end
        S_SEL_CHK: begin
          ent <= ram_rdata;
          beta <= '0;
          if (!ram_rdata.legal) begin
            if (idx == LAST_IDX) begin
              state <= S_SEL_OUT;
            end else begin
              idx <= idx + AW'(1);
              state <= S_SEL_RD;
            end
          end else if (ram_rdata.amaf_count == '0 && ram_rdata.visit_count == '0) begin
            state <= S_SEL_BLEND;
          end else begin
            state <= S_SEL_M0;
          end
        end
        S_SEL_M0: begin
          prod <= 48'(ent.amaf_count) * 48'(ent.visit_count);
          state <= S_SEL_M1;
        end
        S_SEL_M1: begin
          term_lo <= 56'(bsq) * 56'(prod[23:0]);
          state <= S_SEL_M2;
        end
        S_SEL_M2: begin
          term_hi <= 56'(bsq) * 56'(prod[47:24]);
          state <= S_SEL_DEN;
        end
        S_SEL_DEN: begin
          dsh <= (DEN_W+16)'(den) << 16;
          num <= {ent.amaf_count, 40'd0};
          step <= 5'd16;
          state <= S_SEL_DIV;
        end
        S_SEL_DIV: begin
          if (sel_fit) begin
            num <= num - dsh[63:0];
          end
          beta <= {beta[BETA_W-2:0], sel_fit};
          dsh <= dsh >> 1;
          step <= step - 5'd1;
          if (step == 5'd0) begin
            state <= S_SEL_BLEND;
          end
        end
        S_SEL_BLEND: begin
          blend_p <= 37'($signed({1'b0, beta}))
                     * 37'(19'(ent.amaf_mean) - 19'(ent.visit_mean));
          state <= S_SEL_CMP;
        end
        S_SEL_CMP: begin
          if (!found || cand > best_val) begin
            found <= 1'b1;
            best_val <= cand;
            best_idx <= idx;
          end
          if (idx == LAST_IDX) begin
            state <= S_SEL_OUT;
          end else begin
            idx <= idx + AW'(1);
            state <= S_SEL_RD;
          end
        end
        S_SEL_OUT: begin
          // hold until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= found ? {2'b00, 6'(best_idx)} : 8'd0;
            m_axis_tuser <= !found;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_select: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEL_DIV || state == S_SEL_CHK || state == S_SEL_CMP) |-> !ram_we)
    else $error("ram written during select scan");
  a_result_from_select: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == S_SEL_OUT)
    else $error("result beat without a select");
  a_none_legal_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tdata == 8'd0)
    else $error("none_legal with nonzero action");
`endif

endmodule

// File: dv/rave_action_statistics_select_tb.sv
`timescale 1ns / 1ps

module rave_action_statistics_select_tb;
  import ras_pkg::*;

  localparam int NACT = 64;
  localparam int LIMIT_CYCLES = 12000000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] RW_DRAW = 2'b00;
  localparam logic [1:0] RW_WIN = 2'b01;
  localparam logic [1:0] RW_LOSS_ALT = 2'b10;
  localparam logic [1:0] RW_LOSS = 2'b11;

  typedef struct packed {
    logic [5:0] best;
    logic none;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // action[5:0], reward[7:6], legal[8], zero pad
  logic [1:0] s_axis_tuser = '0;   // command[1:0]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // best_act[5:0], zero pad
  logic m_axis_tuser;              // none_legal[0]
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rave_action_statistics_select u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the node statistics
  logic [15:0] bias_q;
  logic st_legal [NACT];
  logic [23:0] st_na [NACT];
  logic signed [17:0] st_am [NACT];
  logic [23:0] st_nm [NACT];
  logic signed [17:0] st_vm [NACT];

  pick_t picks_pending[$];
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int errors = 0;
  int cycles = 0;

  function automatic logic [16:0] rave_weight(logic [23:0] na, logic [23:0] nm);
    logic [127:0] num, den;
    if (na == 0 && nm == 0) return '0;
    num = 128'(na) << 40;
    den = ((128'(nm) + 128'(na)) << 24) + 128'(4) * 128'(bias_q) * 128'(bias_q)
          * 128'(nm) * 128'(na);
    return 17'(num / den);
  endfunction

  function automatic void fold(ref logic [23:0] cnt, ref logic signed [17:0] mean,
                               input longint z);
    longint v;
    if (cnt != COUNT_MAX) cnt = cnt + 24'd1;
    v = longint'(mean) + (z - longint'(mean)) / longint'(cnt);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    mean = 18'(v);
  endfunction

  function automatic void predict_stats(cmd_t cmd, logic [5:0] act, logic [1:0] rw,
                                        logic lg);
    longint z, val, best_val;
    longint beta;
    pick_t p;
    bit found;
    z = (rw == RW_WIN) ? 65536 : (rw == RW_DRAW ? 0 : -65536);
    case (cmd)
      CMD_INIT: begin
        st_legal[act] = lg;
        st_na[act] = AMAF_INIT;
        st_am[act] = '0;
        st_nm[act] = '0;
        st_vm[act] = '0;
      end
      CMD_AMAF: if (st_legal[act]) fold(st_na[act], st_am[act], z);
      CMD_VISIT: if (st_legal[act]) fold(st_nm[act], st_vm[act], z);
      default: begin
        found = 0;
        best_val = 0;
        p = '0;
        for (int a = 0; a < NACT; a++) begin
          if (!st_legal[a]) continue;
          beta = longint'(rave_weight(st_na[a], st_nm[a]));
          val = (65536 - beta) * longint'(st_vm[a]) + beta * longint'(st_am[a]);
          if (!found || val > best_val) begin
            found = 1;
            best_val = val;
            p.best = 6'(a);
          end
        end
        p.none = !found;
        picks_pending.insert(picks_pending.size(), p);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    pick_t exp_p;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (picks_pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat best=%0d none=%0b",
                                   m_axis_tdata[5:0], m_axis_tuser);
      end else begin
        exp_p = picks_pending.pop_front();
        if (m_axis_tdata[5:0] !== exp_p.best || m_axis_tuser !== exp_p.none) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected best=%0d none=%0b, got best=%0d none=%0b",
                     exp_p.best, exp_p.none, m_axis_tdata[5:0], m_axis_tuser);
        end
      end
    end
  end

  task automatic send_item(cmd_t cmd, logic [5:0] act, logic [1:0] rw, logic lg);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, lg, rw, act};
    s_axis_tuser <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    predict_stats(cmd, act, rw, lg);
  endtask

  // hold the stream until every pick is back and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (picks_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bias(logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_BIAS_ADDR;
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bias_q = v;
  endtask

  task automatic test_directed();
    send_item(CMD_SELECT, 6'd0, RW_DRAW, 1'b0);      // nothing legal yet
    send_item(CMD_INIT, 6'd0, RW_DRAW, 1'b1);
    send_item(CMD_INIT, 6'd63, RW_WIN, 1'b1);
    send_item(CMD_SELECT, 6'd63, RW_LOSS, 1'b1);     // tie goes to lowest index
    send_item(CMD_INIT, 6'd5, RW_LOSS, 1'b0);
    send_item(CMD_AMAF, 6'd5, RW_WIN, 1'b1);         // illegal, ignored
    send_item(CMD_VISIT, 6'd5, RW_WIN, 1'b0);
    send_item(CMD_VISIT, 6'd63, RW_WIN, 1'b0);
    send_item(CMD_AMAF, 6'd0, RW_LOSS, 1'b0);
    send_item(CMD_AMAF, 6'd0, RW_LOSS_ALT, 1'b1);    // alternate loss code
    send_item(CMD_VISIT, 6'd0, RW_DRAW, 1'b0);
    send_item(CMD_SELECT, 6'd0, RW_DRAW, 1'b0);
    send_item(CMD_VISIT, 6'd0, RW_LOSS_ALT, 1'b0);
    send_item(CMD_AMAF, 6'd63, RW_WIN, 1'b1);
    send_item(CMD_SELECT, 6'd42, RW_WIN, 1'b1);
    send_item(CMD_INIT, 6'd63, RW_WIN, 1'b0);
    send_item(CMD_INIT, 6'd0, RW_LOSS, 1'b0);
    send_item(CMD_SELECT, 6'd21, RW_LOSS, 1'b0);
    wait_idle();
  endtask

  task automatic test_random(int n_items, logic [15:0] bias);
    int r;
    logic [5:0] act;
    write_bias(bias);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      // most traffic on a few actions so the counts and means get deep
      act = ($urandom_range(99) < 70) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
      if (r < 10) send_item(CMD_INIT, act, 2'($urandom), $urandom_range(99) < 80);
      else if (r < 52) send_item(CMD_AMAF, act, 2'($urandom), 1'($urandom));
      else if (r < 92) send_item(CMD_VISIT, act, 2'($urandom), 1'($urandom));
      else send_item(CMD_SELECT, 6'($urandom), 2'($urandom), 1'($urandom));
      if (i == n_items / 2 && $urandom_range(1)) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    bias_q = '0;
    for (int a = 0; a < NACT; a++) begin
      st_legal[a] = 1'b0;
      st_na[a] = '0;
      st_am[a] = '0;
      st_nm[a] = '0;
      st_vm[a] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 18;
    snk_idle_pct = 55;
    test_directed();
    test_random(360, 16'd0);
    test_random(360, 16'hFFFF);
    src_idle_pct = 55;
    snk_idle_pct = 18;
    test_random(360, 16'($urandom));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(360, 16'd4096);
    if (errors == 0 && picks_pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ras_pkg.sv
hdl/ras_ram.sv
hdl/rave_action_statistics_select.sv
dv/rave_action_statistics_select_tb.sv
